FILE: hdl/npms_pkg.sv
// Shared types and constants for the nth pattern match stream block.
package npms_pkg;

   // Fixed geometry of the configuration registers.
   localparam int TAG_WORD_BITS  = 64;
   localparam int PATTERN_BYTES  = 8;
   localparam int TAG_LEN_BITS   = 4;
   localparam int OCCUR_BITS     = 8;
   localparam int POS_BITS       = 16;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 64;

   // Register indexes on the csr port.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TAG_BYTES    = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TAG_LENGTH   = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_OCCURRENCE   = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_REQUIRE_ROOM = 2'd3;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last;
   } req_payload_type;

   typedef struct packed {
      logic                  found;
      logic [POS_BITS-1:0]   match_start;
      logic [POS_BITS-1:0]   last_end;
      logic [OCCUR_BITS-1:0] matches_counted;
   } rsp_payload_type;

   // Window control from the top level to the compare unit.
   typedef struct packed {
      logic advance;
      logic clear;
   } window_ctrl_type;

endpackage

FILE: hdl/npms_window.sv
// Byte window shift register and tag compare for the pattern match stream.
module npms_window
   import npms_pkg::*;
#(
   parameter int TAG_MAX  = 8,
   parameter int LEN_BITS = $clog2(TAG_MAX + 1)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  window_ctrl_type          ctrl,
   input  logic [7:0]               data_byte,
   input  logic [TAG_WORD_BITS-1:0] tag_bytes,
   input  logic [LEN_BITS-1:0]      tag_len,
   output logic                     hit
);

   logic [7:0]          window_ff [TAG_MAX];
   logic [7:0]          window_in [TAG_MAX];
   logic [LEN_BITS-1:0] fill_ff;
   logic [LEN_BITS-1:0] fill_in;
   logic [7:0]          pattern [PATTERN_BYTES];

   always_comb begin
      for (int k = 0; k < PATTERN_BYTES; k++) begin
         pattern[k] = tag_bytes[8*k +: 8];
      end
   end

   // Window as it looks with the incoming byte shifted in (entry 0 newest).
   always_comb begin
      window_in[0] = data_byte;
      for (int k = 1; k < TAG_MAX; k++) begin
         window_in[k] = window_ff[k-1];
      end
      fill_in = (fill_ff < LEN_BITS'(TAG_MAX)) ? fill_ff + 1'b1 : fill_ff;
   end

   // Oldest of the last tag_len bytes lines up with pattern byte zero.
   always_comb begin
      int       p;
      logic [7:0] pbyte;
      hit = (fill_in >= tag_len);
      for (int j = 0; j < TAG_MAX; j++) begin
         p     = int'(tag_len) - 1 - j;
         pbyte = 8'h00;
         if (p >= 0 && p < PATTERN_BYTES) begin
            pbyte = pattern[p[2:0]];
         end
         if (LEN_BITS'(j) < tag_len && window_in[j] != pbyte) begin
            hit = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (ctrl.advance && ctrl.clear)) begin
         fill_ff <= '0;
         for (int k = 0; k < TAG_MAX; k++) begin
            window_ff[k] <= 8'h00;
         end
      end else if (ctrl.advance) begin
         fill_ff <= fill_in;
         for (int k = 0; k < TAG_MAX; k++) begin
            window_ff[k] <= window_in[k];
         end
      end
   end

endmodule

FILE: hdl/nth_pattern_match_stream.sv
// Top level of the nth pattern match stream: input stage, match tracking, result register.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+----------------------------------------
//   req     | in        | req_valid / req_stall | data_byte, last
//   rsp     | out       | rsp_valid / rsp_stall | found, match_start, last_end, matches_counted
//   csr     | in        | csr_valid / csr_ready | csr_index, csr_data (always ready)
//
// One item per cycle sustained while no last item is held back. An item waits
// in the input register, is matched against the window there, and the last
// item of a buffer writes the result register when it leaves the input register.
// The input register only holds back when a last item meets a result that
// is still stalled on rsp; ordinary bytes keep flowing under a rsp stall.
// Synchronous active-high reset clears stream state and loads the register
// defaults: tag length 1, occurrence 1, room rule on, tag bytes zero.
module nth_pattern_match_stream
   import npms_pkg::*;
#(
   parameter int TAG_MAX    = 8,
   parameter int INDEX_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  req_payload_type           req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rsp_payload_type           rsp_payload,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data
);

   localparam int LEN_BITS = $clog2(TAG_MAX + 1);

   // Configuration registers
   logic [TAG_WORD_BITS-1:0] tag_bytes_ff;
   logic [TAG_LEN_BITS-1:0]  tag_length_ff;
   logic [OCCUR_BITS-1:0]    occurrence_ff;
   logic                     require_room_ff;

   // Input register
   logic       in_valid_ff;
   logic       in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;

   // Stream state
   logic [INDEX_BITS-1:0] byte_index_ff, byte_index_in;
   logic [INDEX_BITS-1:0] next_allowed_ff, next_allowed_in;
   logic [INDEX_BITS-1:0] prev_end_ff, prev_end_in;
   logic [INDEX_BITS-1:0] nth_start_ff, nth_start_in;
   logic [OCCUR_BITS-1:0] match_count_ff, match_count_in;

   // Result register
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_payload_ff, rsp_payload_in;

   logic                  consume;
   logic                  req_accept;
   logic                  rsp_load;
   logic                  hit;
   logic                  take;
   logic                  allowed;
   logic [LEN_BITS-1:0]   eff_len;
   logic [INDEX_BITS-1:0] start_pos;
   logic [INDEX_BITS-1:0] end_pos;
   window_ctrl_type       win_ctrl;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_bytes_ff    <= '0;
         tag_length_ff   <= TAG_LEN_BITS'(1);
         occurrence_ff   <= OCCUR_BITS'(1);
         require_room_ff <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_TAG_BYTES:    tag_bytes_ff    <= csr_data;
            CSR_TAG_LENGTH:   tag_length_ff   <= csr_data[TAG_LEN_BITS-1:0];
            CSR_OCCURRENCE:   occurrence_ff   <= csr_data[OCCUR_BITS-1:0];
            CSR_REQUIRE_ROOM: require_room_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // Zero length acts as one, anything beyond the window as the window size.
   always_comb begin
      if (tag_length_ff == '0) begin
         eff_len = LEN_BITS'(1);
      end else if (32'(tag_length_ff) > 32'(TAG_MAX)) begin
         eff_len = LEN_BITS'(TAG_MAX);
      end else begin
         eff_len = LEN_BITS'(tag_length_ff);
      end
   end

   // A last item needs the result slot free (or freeing this cycle).
   assign consume     = in_valid_ff && (!in_last_ff || !rsp_valid_ff || !rsp_stall);
   assign req_stall   = in_valid_ff && !consume;
   assign req_accept  = req_valid && !req_stall;
   assign in_valid_in = req_accept || (in_valid_ff && !consume);
   assign rsp_load    = consume && in_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_byte_ff <= req_payload.data_byte;
         in_last_ff <= req_payload.last;
      end
   end

   assign win_ctrl.advance = consume;
   assign win_ctrl.clear   = in_last_ff;

   npms_window #(
      .TAG_MAX  (TAG_MAX),
      .LEN_BITS (LEN_BITS)
   ) u_window (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (win_ctrl),
      .data_byte (in_byte_ff),
      .tag_bytes (tag_bytes_ff),
      .tag_len   (eff_len),
      .hit       (hit)
   );

   // Match bookkeeping: start of the candidate, room rule, counting.
   always_comb begin
      start_pos = byte_index_ff - INDEX_BITS'(eff_len - 1'b1);
      end_pos   = byte_index_ff + 1'b1;
      allowed   = (start_pos >= next_allowed_ff) &&
                  !(require_room_ff && in_last_ff && start_pos == next_allowed_ff);
      take      = hit && (match_count_ff < occurrence_ff) && allowed;

      match_count_in  = match_count_ff;
      prev_end_in     = prev_end_ff;
      next_allowed_in = next_allowed_ff;
      nth_start_in    = nth_start_ff;
      if (take) begin
         match_count_in  = match_count_ff + 1'b1;
         prev_end_in     = end_pos;
         next_allowed_in = end_pos;
         if (match_count_in == occurrence_ff) begin
            nth_start_in = start_pos;
         end
      end
      byte_index_in = end_pos;

      // end_pos doubles as the buffer length on the last item
      if (occurrence_ff == '0) begin
         rsp_payload_in.found       = 1'b1;
         rsp_payload_in.match_start = '0;
         rsp_payload_in.last_end    = '0;
      end else begin
         rsp_payload_in.found       = (match_count_in == occurrence_ff);
         rsp_payload_in.match_start = rsp_payload_in.found ? POS_BITS'(nth_start_in)
                                                           : POS_BITS'(end_pos);
         rsp_payload_in.last_end    = (match_count_in != '0) ? POS_BITS'(prev_end_in)
                                                             : POS_BITS'(end_pos);
      end
      rsp_payload_in.matches_counted = match_count_in;
   end

   always_ff @(posedge clock) begin
      if (reset || (consume && in_last_ff)) begin
         byte_index_ff   <= '0;
         next_allowed_ff <= '0;
         prev_end_ff     <= '0;
         match_count_ff  <= '0;
         nth_start_ff    <= '0;
      end else if (consume) begin
         byte_index_ff   <= byte_index_in;
         next_allowed_ff <= next_allowed_in;
         prev_end_ff     <= prev_end_in;
         match_count_ff  <= match_count_in;
         nth_start_ff    <= nth_start_in;
      end
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // A buffered item is never dropped without being consumed.
   a_in_hold : assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !consume |=> in_valid_ff)
      else $error("input item lost");

   // Ordinary bytes step the index by one.
   a_index_step : assert property (@(posedge clock) disable iff (reset)
      consume && !in_last_ff |=> byte_index_ff == $past(byte_index_ff) + 1'b1)
      else $error("byte index did not advance");

   // The end of a buffer leaves the stream state cleared.
   a_clear_after_last : assert property (@(posedge clock) disable iff (reset)
      consume && in_last_ff |=> byte_index_ff == '0 && match_count_ff == '0)
      else $error("stream state not cleared");

   // Match ends only move when a match has been counted.
   a_no_end_without_match : assert property (@(posedge clock) disable iff (reset)
      match_count_ff == '0 |-> prev_end_ff == '0 && next_allowed_ff == '0)
      else $error("match end set without a counted match");

   // A held result is not overwritten.
   a_rsp_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |-> !rsp_load)
      else $error("pending result overwritten");

endmodule
